@@ rtl/slrg_pkg.sv @@
`timescale 1ns / 1ps

package slrg_pkg;

    localparam int TABLE_SIZE = 32;
    localparam int IDX_W      = $clog2(TABLE_SIZE);
    localparam int DATA_W     = 31;
    localparam int MULT_W     = 15;
    localparam int PROD_W     = DATA_W + MULT_W;
    localparam int WARMUP     = TABLE_SIZE + 8;
    localparam int CNT_W      = $clog2(WARMUP);

    localparam logic [MULT_W-1:0] LCG_MULT = MULT_W'(16807);
    localparam logic [DATA_W-1:0] LCG_MOD  = {DATA_W{1'b1}};
    localparam logic [DATA_W-1:0] SLOT_DIV =
        DATA_W'(1 + (2147483647 - 1) / TABLE_SIZE);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INIT_MUL,
        ST_INIT_RED,
        ST_DRAW_MUL,
        ST_DRAW_RED
    } state_t;

endpackage

@@ rtl/slrg_ram.sv @@
`timescale 1ns / 1ps

module slrg_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                       clk,
    input  logic                       wr_en,
    input  logic [$clog2(DEPTH)-1:0]   wr_addr,
    input  logic [WIDTH-1:0]           wr_data,
    input  logic                       rd_en,
    input  logic [$clog2(DEPTH)-1:0]   rd_addr,
    output logic [WIDTH-1:0]           rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ rtl/slrg_lcg.sv @@
`timescale 1ns / 1ps

module slrg_lcg (
    input  logic                        clk,
    input  logic                        load,
    input  logic [slrg_pkg::DATA_W-1:0] x,
    output logic [slrg_pkg::DATA_W-1:0] result
);

    import slrg_pkg::*;

    logic [PROD_W-1:0] prod_reg;
    logic [DATA_W:0]   fold;

    always_ff @(posedge clk) begin
        if (load) begin
            prod_reg <= PROD_W'(x) * PROD_W'(LCG_MULT);
        end
    end

    // 2^31 == 1 mod (2^31-1): fold high part onto low part, one correction
    always_comb begin
        fold = {1'b0, prod_reg[DATA_W-1:0]} + (DATA_W+1)'(prod_reg[PROD_W-1:DATA_W]);
        if (fold >= {1'b0, LCG_MOD}) begin
            result = DATA_W'(fold - {1'b0, LCG_MOD});
        end else begin
            result = fold[DATA_W-1:0];
        end
    end

endmodule

@@ rtl/shuffled_lcg_random_generator.sv @@
`timescale 1ns / 1ps

// Minimal standard generator (x * 16807 mod 2^31-1) behind a 32-entry
// Bays-Durham shuffle table. Each transfer on the s_ side yields one value
// in 1 .. 2^31-2 on the m_ side. The first request after reset, and any
// request with restart set, first reloads the generator from seed (0 or
// 2^31-1 act as 1) and fills the table. Timing is set by the shared
// multiply-and-fold unit, which registers the product in one state and
// folds it in the next for each generator step: a plain draw holds
// s_tready low through its multiply and reduce states, a draw with
// initialization also through 40 warmup steps. A finished value waits in
// the output register while the next request is taken; a draw stalls on
// its last cycle only if that register is still full. The seed is written
// over cfg_* and takes effect at the next initialization.
module shuffled_lcg_random_generator (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [0] restart, [7:1] zero
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [30:0] value, [31] zero
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [30:0] cfg_data
);

    import slrg_pkg::*;

    state_t state_reg, state_next;

    logic [DATA_W-1:0] seed_reg, seed_next;
    logic [DATA_W-1:0] lcg_reg, lcg_next;
    logic [DATA_W-1:0] last_reg, last_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              init_pending_reg, init_pending_next;
    logic              m_tvalid_reg, m_tvalid_next;
    logic [DATA_W-1:0] out_reg, out_next;

    logic              s_xfer;
    logic              out_free;
    logic [DATA_W-1:0] seed_fixed;
    logic [DATA_W-1:0] step_val;
    logic [DATA_W-1:0] slot_full;
    logic [IDX_W-1:0]  slot;
    logic              mul_load;
    logic              ram_wr_en;
    logic [IDX_W-1:0]  ram_wr_addr;
    logic [DATA_W-1:0] ram_wr_data;
    logic              ram_rd_en;
    logic [DATA_W-1:0] ram_rd_data;

    assign s_tready  = (state_reg == ST_IDLE);
    assign s_xfer    = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = {1'b0, out_reg};
    assign out_free  = !m_tvalid_reg || m_tready;

    assign seed_fixed = (seed_reg == '0 || seed_reg == LCG_MOD) ? DATA_W'(1) : seed_reg;

    assign slot_full = last_reg / SLOT_DIV;
    assign slot      = (slot_full >= DATA_W'(TABLE_SIZE)) ? IDX_W'(TABLE_SIZE - 1)
                                                           : slot_full[IDX_W-1:0];

    slrg_lcg u_lcg (
        .clk    (aclk),
        .load   (mul_load),
        .x      (lcg_reg),
        .result (step_val)
    );

    slrg_ram #(
        .WIDTH (DATA_W),
        .DEPTH (TABLE_SIZE)
    ) u_table (
        .clk     (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (slot),
        .rd_data (ram_rd_data)
    );

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_xfer) begin
                    state_next = (s_tdata[0] || init_pending_reg) ? ST_INIT_MUL : ST_DRAW_MUL;
                end
            end
            ST_INIT_MUL: state_next = ST_INIT_RED;
            ST_INIT_RED: begin
                state_next = (cnt_reg == '0) ? ST_DRAW_MUL : ST_INIT_MUL;
            end
            ST_DRAW_MUL: state_next = ST_DRAW_RED;
            ST_DRAW_RED: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // datapath and control outputs
    always_comb begin
        seed_next         = seed_reg;
        lcg_next          = lcg_reg;
        last_next         = last_reg;
        cnt_next          = cnt_reg;
        init_pending_next = init_pending_reg;
        m_tvalid_next     = m_tvalid_reg;
        out_next          = out_reg;
        mul_load          = 1'b0;
        ram_wr_en         = 1'b0;
        ram_wr_addr       = cnt_reg[IDX_W-1:0];
        ram_wr_data       = step_val;
        ram_rd_en         = 1'b0;

        if (cfg_valid && cfg_ready) begin
            seed_next = cfg_data;
        end
        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_xfer && (s_tdata[0] || init_pending_reg)) begin
                    lcg_next          = seed_fixed;
                    cnt_next          = CNT_W'(WARMUP - 1);
                    init_pending_next = 1'b0;
                end
            end
            ST_INIT_MUL: begin
                mul_load = 1'b1;
            end
            ST_INIT_RED: begin
                lcg_next = step_val;
                // only the last TABLE_SIZE warmup steps land in the table
                ram_wr_en = (cnt_reg < CNT_W'(TABLE_SIZE));
                if (cnt_reg == '0) begin
                    last_next = step_val;
                end else begin
                    cnt_next = cnt_reg - CNT_W'(1);
                end
            end
            ST_DRAW_MUL: begin
                mul_load  = 1'b1;
                ram_rd_en = 1'b1;
            end
            ST_DRAW_RED: begin
                // prod and read data hold while the output register is full
                if (out_free) begin
                    lcg_next      = step_val;
                    last_next     = ram_rd_data;
                    out_next      = ram_rd_data;
                    m_tvalid_next = 1'b1;
                    ram_wr_en     = 1'b1;
                    ram_wr_addr   = slot;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= ST_IDLE;
            seed_reg         <= DATA_W'(1);
            lcg_reg          <= DATA_W'(1);
            last_reg         <= '0;
            cnt_reg          <= '0;
            init_pending_reg <= 1'b1;
            m_tvalid_reg     <= 1'b0;
        end else begin
            state_reg        <= state_next;
            seed_reg         <= seed_next;
            lcg_reg          <= lcg_next;
            last_reg         <= last_next;
            cnt_reg          <= cnt_next;
            init_pending_reg <= init_pending_next;
            m_tvalid_reg     <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_reg <= out_next;
    end

endmodule

@@ rtl/slrg_checker.sv @@
`timescale 1ns / 1ps

module slrg_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata
);

    // a held result keeps its value until the transfer
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // every value is a nonzero residue below the modulus
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[31] == 1'b0 && m_tdata[30:0] != 31'd0
                     && m_tdata[30:0] != 31'h7fffffff)
        else $error("value out of range");

    // after a taken request, s_tready stays low while the draw works
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready ##1 !s_tready)
        else $error("request taken while busy");

    // no result appears straight out of reset
    assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

bind shuffled_lcg_random_generator slrg_checker u_slrg_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
